// ----- rtl/core/bps_pkg.sv -----
// ----------------------------------------------------------------------------
// bps_pkg
// Shared types and constants for the Buchi product successor block.
// ----------------------------------------------------------------------------
`default_nettype none

package bps_pkg;

    // Table geometry
    localparam int NUM_STATES      = 64;
    localparam int NUM_TRANSITIONS = 256;
    localparam int NUM_PREDICATES  = 32;
    localparam int STATE_AW        = 6;
    localparam int TRANS_AW        = 8;
    localparam int CNT_W           = 5;

    localparam logic [8:0]       STATE_LIMIT   = 9'(NUM_STATES);
    localparam logic [8:0]       TRANS_LIMIT   = 9'(NUM_TRANSITIONS);
    localparam logic [CNT_W-1:0] MAX_OUT_TRANS = 5'd16;

    // Input transfer kinds
    localparam logic [1:0] KIND_WR_STATE = 2'd0;
    localparam logic [1:0] KIND_WR_TRANS = 2'd1;
    localparam logic [1:0] KIND_STEP     = 2'd2;
    localparam logic [1:0] KIND_RSVD     = 2'd3;

    // Command queue depth
    localparam int FIFO_DEPTH = 2;

    typedef enum logic [1:0] {
        OP_WR_STATE,
        OP_WR_TRANS,
        OP_STEP
    } op_t;

    // Classified command handed from front to back
    typedef struct packed {
        op_t                       op;
        logic                      idx_ok;    // index within its table
        logic [7:0]                index;     // state, transition or step source
        logic [NUM_PREDICATES-1:0] pred_bits;
        logic [NUM_PREDICATES-1:0] pos_mask;
        logic [NUM_PREDICATES-1:0] neg_mask;
        logic [STATE_AW-1:0]       target_state;
        logic                      accepting;
        logic [TRANS_AW-1:0]       first_trans;
        logic [CNT_W-1:0]          trans_count; // already saturated
    } cmd_t;

    typedef struct packed {
        logic                accepting;
        logic [TRANS_AW-1:0] first_trans;
        logic [CNT_W-1:0]    ntrans;
    } state_entry_t;

    typedef struct packed {
        logic [NUM_PREDICATES-1:0] pos_mask;
        logic [NUM_PREDICATES-1:0] neg_mask;
        logic [STATE_AW-1:0]       target_state;
    } trans_entry_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_SREAD,
        BK_WALK,
        BK_SUMMARY
    } back_state_t;

endpackage

`default_nettype wire

// ----- rtl/core/bps_front.sv -----
// ----------------------------------------------------------------------------
// bps_front
// Accepts input transfers, decodes and range-checks them, and queues the
// resulting commands for the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module bps_front (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_valid,
    output logic               in_ready,
    input  wire logic [127:0]  in_data,
    input  wire logic [1:0]    in_kind,
    output logic               cmd_valid,
    input  wire logic          cmd_pop,
    output bps_pkg::cmd_t      cmd
);
    import bps_pkg::*;

    logic [7:0]          in_index;
    logic                in_from_initial;
    logic [7:0]          src;
    logic [CNT_W-1:0]    in_count;
    logic                push;
    cmd_t                cmd_in;

    cmd_t                fifo_reg [FIFO_DEPTH];
    logic                wr_ptr_reg, wr_ptr_next;
    logic                rd_ptr_reg, rd_ptr_next;
    logic [1:0]          count_reg, count_next;

    assign in_index        = in_data[7:0];
    assign in_from_initial = in_data[8];
    assign in_count        = in_data[124:120];
    assign src             = in_from_initial ? 8'd0 : in_index;

    // Decode one input transfer into a command
    always_comb
    begin
        cmd_in.op           = OP_STEP;
        cmd_in.idx_ok       = 1'b0;
        cmd_in.index        = in_index;
        cmd_in.pred_bits    = in_data[40:9];
        cmd_in.pos_mask     = in_data[72:41];
        cmd_in.neg_mask     = in_data[104:73];
        cmd_in.target_state = in_data[110:105];
        cmd_in.accepting    = in_data[111];
        cmd_in.first_trans  = in_data[119:112];
        cmd_in.trans_count  = (in_count > MAX_OUT_TRANS) ? MAX_OUT_TRANS : in_count;
        push                = in_valid && in_ready;
        unique case (in_kind)
            KIND_WR_STATE:
            begin
                cmd_in.op     = OP_WR_STATE;
                cmd_in.idx_ok = {1'b0, in_index} < STATE_LIMIT;
            end
            KIND_WR_TRANS:
            begin
                cmd_in.op     = OP_WR_TRANS;
                cmd_in.idx_ok = {1'b0, in_index} < TRANS_LIMIT;
            end
            KIND_STEP:
            begin
                cmd_in.op     = OP_STEP;
                cmd_in.index  = src;
                cmd_in.idx_ok = {1'b0, src} < STATE_LIMIT;
            end
            KIND_RSVD:
            begin
                // unknown kind: consumed, no result
                push = 1'b0;
            end
        endcase
    end

    // Command queue
    assign in_ready  = count_reg != 2'(FIFO_DEPTH);
    assign cmd_valid = count_reg != 2'd0;
    assign cmd       = fifo_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = cmd_pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(push) - 2'(cmd_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            fifo_reg[wr_ptr_reg] <= cmd_in;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/core/bps_back.sv -----
// ----------------------------------------------------------------------------
// bps_back
// Holds the state and transition tables, carries out queued commands, walks a
// source's transitions one per cycle into the result register while it has room.
// ----------------------------------------------------------------------------
`default_nettype none

module bps_back (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          cmd_valid,
    output logic               cmd_pop,
    input  wire bps_pkg::cmd_t cmd,
    output logic               out_valid,
    input  wire logic          out_ready,
    output logic [15:0]        out_data,
    output logic               out_succ,
    output logic               out_last
);
    import bps_pkg::*;

    // Tables
    state_entry_t        state_mem [NUM_STATES];
    trans_entry_t        trans_mem [NUM_TRANSITIONS];
    state_entry_t        st_rd_reg;
    trans_entry_t        tr_rd_reg;

    logic                st_we, st_re, tr_we, tr_re;
    logic [TRANS_AW-1:0] tr_raddr;
    logic                hit;
    logic                out_free;
    logic                out_load;
    logic                ld_succ, ld_last;
    logic [STATE_AW-1:0] ld_next;
    logic                ld_acc;
    logic [CNT_W-1:0]    ld_cnt;

    back_state_t                state_reg, state_next;
    logic [CNT_W-1:0]           j_reg, j_next;
    logic [CNT_W-1:0]           n_reg, n_next;
    logic [CNT_W-1:0]           match_reg, match_next;
    logic [TRANS_AW-1:0]        first_reg, first_next;
    logic                       acc_reg, acc_next;
    logic                       src_ok_reg, src_ok_next;
    logic [NUM_PREDICATES-1:0]  pred_reg, pred_next;

    logic                out_valid_reg;
    logic                out_succ_reg, out_last_reg, out_acc_reg;
    logic [STATE_AW-1:0] out_next_reg;
    logic [CNT_W-1:0]    out_cnt_reg;

    assign out_free = !out_valid_reg || out_ready;
    assign hit = ((pred_reg & tr_rd_reg.pos_mask) == tr_rd_reg.pos_mask) &&
                 ((pred_reg & tr_rd_reg.neg_mask) == '0);

    // Sequencer
    always_comb
    begin
        state_next  = state_reg;
        j_next      = j_reg;
        n_next      = n_reg;
        match_next  = match_reg;
        first_next  = first_reg;
        acc_next    = acc_reg;
        src_ok_next = src_ok_reg;
        pred_next   = pred_reg;
        cmd_pop     = 1'b0;
        st_we       = 1'b0;
        st_re       = 1'b0;
        tr_we       = 1'b0;
        tr_re       = 1'b0;
        tr_raddr    = first_reg;
        out_load    = 1'b0;
        ld_succ     = 1'b0;
        ld_next     = '0;
        ld_acc      = 1'b0;
        ld_cnt      = '0;
        ld_last     = 1'b1;
        unique case (state_reg)
            BK_IDLE:
            begin
                if (cmd_valid && out_free)
                begin
                    cmd_pop = 1'b1;
                    unique case (cmd.op)
                        OP_WR_STATE:
                        begin
                            st_we    = cmd.idx_ok;
                            out_load = 1'b1;
                        end
                        OP_WR_TRANS:
                        begin
                            tr_we    = cmd.idx_ok;
                            out_load = 1'b1;
                        end
                        OP_STEP:
                        begin
                            st_re       = 1'b1;
                            src_ok_next = cmd.idx_ok;
                            pred_next   = cmd.pred_bits;
                            state_next  = BK_SREAD;
                        end
                        default:
                        begin
                            out_load = 1'b1;
                        end
                    endcase
                end
            end
            BK_SREAD:
            begin
                // state entry is in st_rd_reg now
                acc_next   = src_ok_reg & st_rd_reg.accepting;
                n_next     = src_ok_reg ? st_rd_reg.ntrans : '0;
                first_next = st_rd_reg.first_trans;
                j_next     = '0;
                match_next = '0;
                if (src_ok_reg && st_rd_reg.ntrans != '0)
                begin
                    tr_re      = 1'b1;
                    tr_raddr   = st_rd_reg.first_trans;
                    state_next = BK_WALK;
                end
                else
                begin
                    state_next = BK_SUMMARY;
                end
            end
            BK_WALK:
            begin
                // one transition per cycle; stall only when a hit cannot go out
                if (!hit || out_free)
                begin
                    if (hit)
                    begin
                        out_load   = 1'b1;
                        ld_succ    = 1'b1;
                        ld_next    = tr_rd_reg.target_state;
                        ld_acc     = acc_reg;
                        ld_last    = 1'b0;
                        match_next = match_reg + 5'd1;
                    end
                    j_next = j_reg + 5'd1;
                    if (j_next < n_reg)
                    begin
                        tr_re    = 1'b1;
                        tr_raddr = first_reg + TRANS_AW'(j_next);
                    end
                    else
                    begin
                        state_next = BK_SUMMARY;
                    end
                end
            end
            BK_SUMMARY:
            begin
                if (out_free)
                begin
                    out_load   = 1'b1;
                    ld_acc     = acc_reg;
                    ld_cnt     = match_reg;
                    state_next = BK_IDLE;
                end
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Walk context and result payload
    always_ff @(posedge clk)
    begin
        j_reg      <= j_next;
        n_reg      <= n_next;
        match_reg  <= match_next;
        first_reg  <= first_next;
        acc_reg    <= acc_next;
        src_ok_reg <= src_ok_next;
        pred_reg   <= pred_next;
        if (out_load)
        begin
            out_succ_reg <= ld_succ;
            out_next_reg <= ld_next;
            out_acc_reg  <= ld_acc;
            out_cnt_reg  <= ld_cnt;
            out_last_reg <= ld_last;
        end
    end

    // State table
    always_ff @(posedge clk)
    begin
        if (st_we)
        begin
            state_mem[cmd.index[STATE_AW-1:0]] <= '{accepting:   cmd.accepting,
                                                   first_trans: cmd.first_trans,
                                                   ntrans:      cmd.trans_count};
        end
        if (st_re)
        begin
            st_rd_reg <= state_mem[cmd.index[STATE_AW-1:0]];
        end
    end

    // Transition table
    always_ff @(posedge clk)
    begin
        if (tr_we)
        begin
            trans_mem[cmd.index[TRANS_AW-1:0]] <= '{pos_mask:     cmd.pos_mask,
                                                   neg_mask:     cmd.neg_mask,
                                                   target_state: cmd.target_state};
        end
        if (tr_re)
        begin
            tr_rd_reg <= trans_mem[tr_raddr];
        end
    end

    assign out_valid = out_valid_reg;
    assign out_succ  = out_succ_reg;
    assign out_last  = out_last_reg;
    assign out_data  = {4'd0, out_cnt_reg, out_acc_reg, out_next_reg};

endmodule

`default_nettype wire

// ----- rtl/core/buchi_product_successor_top.sv -----
// ----------------------------------------------------------------------------
// buchi_product_successor_top
// Buchi automaton table with a successor walk for product state steps.
// ----------------------------------------------------------------------------
// Usage:
//   The s_axis channel takes table writes and step commands, selected by
//   s_axis_tuser (0 state write, 1 transition write, 2 step, 3 dropped).
//   Each write returns one acknowledge transfer with tlast set. A step
//   returns one transfer per enabled transition of the source state
//   (tuser = 1), then a summary transfer (tuser = 0, tlast = 1) carrying
//   the match count and the source's accepting flag.
//   A step reads the state table entry of its source, then each of its n
//   transitions (n <= 16) in turn through the single transition table read
//   port, then sends the summary. A two-entry command queue sits between
//   input and the walk engine, so input is taken while a result waits in the
//   output register. Reset clears control state only; tables hold no value
//   until written. When m_axis_tready is low the walk holds at the next hit,
//   the queue fills, and s_axis_tready drops once two commands are waiting.
// ----------------------------------------------------------------------------
`default_nettype none

module buchi_product_successor_top (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    // index[7:0], from_initial[8], pred_bits[40:9], pos_mask[72:41],
    // neg_mask[104:73], target_state[110:105], accepting[111],
    // first_trans[119:112], trans_count[124:120], zero [127:125]
    input  wire logic [127:0] s_axis_tdata,
    // kind[1:0]
    input  wire logic [1:0]   s_axis_tuser,
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    // next_state[5:0], source_accepting[6], match_count[11:7], zero [15:12]
    output logic [15:0]       m_axis_tdata,
    // is_successor[0]
    output logic              m_axis_tuser,
    output logic              m_axis_tlast
);
    import bps_pkg::*;

    logic cmd_valid;
    logic cmd_pop;
    cmd_t cmd;

    bps_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_data   (s_axis_tdata),
        .in_kind   (s_axis_tuser),
        .cmd_valid (cmd_valid),
        .cmd_pop   (cmd_pop),
        .cmd       (cmd)
    );

    bps_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_pop   (cmd_pop),
        .cmd       (cmd),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (m_axis_tdata),
        .out_succ  (m_axis_tuser),
        .out_last  (m_axis_tlast)
    );

endmodule

`default_nettype wire

// ----- tb/tb_buchi_product_successor_top.sv -----
// ----------------------------------------------------------------------------
// tb_buchi_product_successor_top
// Checks the Buchi product successor block through its stream ports. The
// testbench loads state and transition entries, issues successor steps and
// predicts every acknowledge, successor and summary transfer from its own copy
// of the tables. A short directed pass comes first. Random traffic follows:
// mostly table fills with steps over them, with some stray items mixed in.
// Both sides of the block stall at random.
// ----------------------------------------------------------------------------

module tb_buchi_product_successor_top;
    import bps_pkg::*;

    localparam int IDLE_LIMIT   = 4000;
    localparam int HOLD_CYCLES  = 200;
    localparam int RANDOM_ITEMS = 70;
    localparam int CALM_ITEMS   = 20;
    localparam int DRAIN_CYCLES = 24;

    // One input item, unpacked
    typedef struct {
        logic [1:0]  kind;
        logic [7:0]  index;
        logic        from_init;
        logic [31:0] pred;
        logic [31:0] pos;
        logic [31:0] neg;
        logic [5:0]  target;
        logic        accepting;
        logic [7:0]  first;
        logic [4:0]  count;
    } bps_cmd_t;

    // One output transfer, field by field
    typedef struct {
        logic       succ;
        logic [5:0] next;
        logic       acc;
        logic [4:0] cnt;
        logic       last;
    } succ_result_t;

    // Table copy, successor prediction and result checking
    class successor_scoreboard;
        logic        st_accept [NUM_STATES];
        logic [7:0]  st_first  [NUM_STATES];
        logic [4:0]  st_count  [NUM_STATES];
        logic [31:0] tr_pos    [NUM_TRANSITIONS];
        logic [31:0] tr_neg    [NUM_TRANSITIONS];
        logic [5:0]  tr_target [NUM_TRANSITIONS];
        succ_result_t pending [$];
        int errors     = 0;
        int writes     = 0;
        int steps      = 0;
        int successors = 0;
        int results    = 0;

        task report_mismatch(input string msg);
            $display("MISMATCH @%0t: %s", $time, msg);
            errors++;
        endtask

        // Work out the transfers caused by one accepted input transfer
        function void note_input(input logic [1:0] kind, input logic [127:0] d);
            logic [7:0]  src;
            logic [7:0]  t;
            logic [31:0] bits;
            logic [4:0]  cnt;
            logic        acc;
            int          hits;
            case (kind)
                KIND_WR_STATE:
                begin
                    if (d[7:0] < NUM_STATES)
                    begin
                        cnt = d[124:120];
                        if (cnt > MAX_OUT_TRANS)
                            cnt = MAX_OUT_TRANS;
                        st_accept[d[7:0]] = d[111];
                        st_first[d[7:0]]  = d[119:112];
                        st_count[d[7:0]]  = cnt;
                    end
                    pending.push_back('{1'b0, 6'd0, 1'b0, 5'd0, 1'b1});
                    writes++;
                end
                KIND_WR_TRANS:
                begin
                    tr_pos[d[7:0]]    = d[72:41];
                    tr_neg[d[7:0]]    = d[104:73];
                    tr_target[d[7:0]] = d[110:105];
                    pending.push_back('{1'b0, 6'd0, 1'b0, 5'd0, 1'b1});
                    writes++;
                end
                KIND_STEP:
                begin
                    // initial marker stands for state 0
                    src  = d[8] ? 8'd0 : d[7:0];
                    bits = d[40:9];
                    acc  = 1'b0;
                    hits = 0;
                    if (src < NUM_STATES)
                    begin
                        acc = st_accept[src];
                        for (int j = 0; j < st_count[src]; j++)
                        begin
                            t = st_first[src] + 8'(j);  // wraps around the table
                            if ((bits & tr_pos[t]) == tr_pos[t] && (bits & tr_neg[t]) == 32'd0)
                            begin
                                pending.push_back('{1'b1, tr_target[t], acc, 5'd0, 1'b0});
                                hits++;
                            end
                        end
                    end
                    pending.push_back('{1'b0, 6'd0, acc, 5'(hits), 1'b1});
                    steps++;
                    successors += hits;
                end
                default: ;  // reserved kind is dropped
            endcase
        endfunction

        // Compare one output transfer with the oldest expectation
        task check_result(input logic [15:0] d, input logic user, input logic last);
            succ_result_t e;
            results++;
            if (pending.size() == 0)
            begin
                report_mismatch($sformatf("unexpected transfer tdata=%h tuser=%b tlast=%b",
                                          d, user, last));
                return;
            end
            e = pending.pop_front();
            if (user !== e.succ)
                report_mismatch($sformatf("transfer %0d is_successor %b, want %b",
                                          results, user, e.succ));
            if (d[5:0] !== e.next)
                report_mismatch($sformatf("transfer %0d next_state %0d, want %0d",
                                          results, d[5:0], e.next));
            if (d[6] !== e.acc)
                report_mismatch($sformatf("transfer %0d source_accepting %b, want %b",
                                          results, d[6], e.acc));
            if (d[11:7] !== e.cnt)
                report_mismatch($sformatf("transfer %0d match_count %0d, want %0d",
                                          results, d[11:7], e.cnt));
            if (last !== e.last)
                report_mismatch($sformatf("transfer %0d last %b, want %b",
                                          results, last, e.last));
        endtask
    endclass

    logic         clk           = 1'b0;
    logic         rst_n         = 1'b0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [127:0] s_axis_tdata  = '0;
    logic [1:0]   s_axis_tuser  = '0;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [15:0]  m_axis_tdata;
    logic         m_axis_tuser;
    logic         m_axis_tlast;

    successor_scoreboard sb = new;

    int idle_cycles = 0;
    int items_sent  = 0;
    bit gaps_on     = 1'b1;
    bit hold_req    = 1'b0;

    // What the tables hold as issued, so steps only read written entries
    bit         gen_st_valid [NUM_STATES];
    logic [7:0] gen_st_first [NUM_STATES];
    logic [4:0] gen_st_count [NUM_STATES];
    bit         gen_tr_valid [NUM_TRANSITIONS];

    buchi_product_successor_top dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #1 clk = ~clk;

    // Transfer monitor: check results, predict from inputs, track activity
    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_result(m_axis_tdata, m_axis_tuser, m_axis_tlast);
        if (rst_n && s_axis_tvalid && s_axis_tready)
            sb.note_input(s_axis_tuser, s_axis_tdata);
        if (rst_n && ((m_axis_tvalid && m_axis_tready) || (s_axis_tvalid && s_axis_tready)))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
    end

    // Watchdog on cycles without any transfer
    initial
    begin
        while (idle_cycles < IDLE_LIMIT)
            @(posedge clk);
        $display("watchdog: no transfer for %0d cycles", IDLE_LIMIT);
        $display("tb_buchi_product_successor_top: done, errors");
        $finish;
    end

    // Receiver: ready runs, random stall bursts, one long hold on request
    initial
    begin
        @(negedge clk);
        forever
        begin
            if (hold_req)
            begin
                hold_req = 1'b0;
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
            end
            else if (gaps_on && $urandom_range(0, 3) == 0)
            begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 6)) @(negedge clk);
            end
            else
            begin
                m_axis_tready <= 1'b1;
                repeat ($urandom_range(1, 8)) @(negedge clk);
            end
        end
    end

    function automatic bit can_step(input int s);
        if (!gen_st_valid[s])
            return 1'b0;
        for (int j = 0; j < gen_st_count[s]; j++)
            if (!gen_tr_valid[8'(gen_st_first[s] + j)])
                return 1'b0;
        return 1'b1;
    endfunction

    function automatic bps_cmd_t random_cmd();
        bps_cmd_t c;
        c.kind      = 2'($urandom_range(0, 3));
        c.index     = 8'($urandom);
        c.from_init = 1'($urandom);
        c.pred      = $urandom;
        c.pos       = $urandom;
        c.neg       = $urandom;
        c.target    = 6'($urandom);
        c.accepting = 1'($urandom);
        c.first     = 8'($urandom);
        c.count     = 5'($urandom);
        return c;
    endfunction

    // Mostly sparse masks, so that transitions fire often enough
    function automatic logic [31:0] sparse_mask();
        case ($urandom_range(0, 5))
            0:       return 32'd0;
            1, 2:    return 32'd1 << $urandom_range(0, 31);
            3:       return (32'd1 << $urandom_range(0, 31)) | (32'd1 << $urandom_range(0, 31));
            4:       return $urandom & $urandom & $urandom;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [31:0] pred_pick();
        case ($urandom_range(0, 5))
            0:       return 32'd0;
            1:       return 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    // Offer one item and hold it until the input transfer happens
    task automatic drive_cmd(input bps_cmd_t c);
        if (c.kind == KIND_WR_STATE && c.index < NUM_STATES)
        begin
            gen_st_valid[c.index] = 1'b1;
            gen_st_first[c.index] = c.first;
            gen_st_count[c.index] = (c.count > MAX_OUT_TRANS) ? MAX_OUT_TRANS : c.count;
        end
        if (c.kind == KIND_WR_TRANS)
            gen_tr_valid[c.index] = 1'b1;
        if (c.kind != KIND_RSVD)
            items_sent++;
        @(negedge clk);
        if (gaps_on && $urandom_range(0, 4) == 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= c.kind;
        s_axis_tdata  <= {3'b000, c.count, c.first, c.accepting, c.target,
                          c.neg, c.pos, c.pred, c.from_init, c.index};
        do
            @(posedge clk);
        while (!s_axis_tready);
    endtask

    task automatic wr_state(input logic [7:0] idx, input logic acc,
                            input logic [7:0] first, input logic [4:0] count);
        bps_cmd_t c;
        c           = random_cmd();
        c.kind      = KIND_WR_STATE;
        c.index     = idx;
        c.accepting = acc;
        c.first     = first;
        c.count     = count;
        drive_cmd(c);
    endtask

    task automatic wr_trans(input logic [7:0] idx, input logic [31:0] pos,
                            input logic [31:0] neg, input logic [5:0] target);
        bps_cmd_t c;
        c        = random_cmd();
        c.kind   = KIND_WR_TRANS;
        c.index  = idx;
        c.pos    = pos;
        c.neg    = neg;
        c.target = target;
        drive_cmd(c);
    endtask

    task automatic step_state(input logic [7:0] idx, input logic from_init,
                              input logic [31:0] pred);
        bps_cmd_t c;
        c           = random_cmd();
        c.kind      = KIND_STEP;
        c.index     = idx;
        c.from_init = from_init;
        c.pred      = pred;
        drive_cmd(c);
    endtask

    // Step any loaded state, or a source past the state table
    task automatic step_any();
        int pick [$];
        int s;
        for (int i = 0; i < NUM_STATES; i++)
            if (can_step(i))
                pick.push_back(i);
        if (pick.size() == 0 || $urandom_range(0, 3) == 0)
            step_state(8'($urandom_range(NUM_STATES, 255)), 1'b0, pred_pick());
        else
        begin
            s = pick[$urandom_range(0, pick.size() - 1)];
            if (s == 0 && $urandom_range(0, 1))
                step_state(8'($urandom), 1'b1, pred_pick());
            else
                step_state(8'(s), 1'b0, pred_pick());
        end
    endtask

    // Fill a block of transitions, point a state at it, then step it
    task automatic run_sequence();
        int         k;
        int         base;
        int         sidx;
        logic [4:0] cnt;
        k    = ($urandom_range(0, 5) == 0) ? 16 : $urandom_range(0, 4);
        base = $urandom_range(0, NUM_TRANSITIONS - 1);
        sidx = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(0, NUM_STATES - 1);
        cnt  = 5'(k);
        if (k == 16 && $urandom_range(0, 1))
            cnt = 5'($urandom_range(17, 31));
        for (int j = 0; j < k; j++)
            wr_trans(8'(base + j), sparse_mask(), sparse_mask(), 6'($urandom));
        wr_state(8'(sidx), 1'($urandom), 8'(base), cnt);
        repeat ($urandom_range(1, 3))
        begin
            if (sidx == 0 && $urandom_range(0, 1))
                step_state(8'($urandom), 1'b1, pred_pick());
            else
                step_state(8'(sidx), 1'b0, pred_pick());
        end
    endtask

    // Stimulus and end of run
    initial
    begin
        int       start;
        bps_cmd_t c;
        logic [31:0] pos;
        logic [31:0] neg;
        logic [5:0]  tgt;

        repeat (5) @(negedge clk);
        rst_n <= 1'b1;

        // sixteen transitions 250..255, 0..9, one block that wraps the table
        for (int j = 0; j < 16; j++)
        begin
            case (j)
                0:       begin pos = 32'd0;         neg = 32'd0;         tgt = 6'd63; end
                1:       begin pos = 32'hFFFF_FFFF; neg = 32'd0;         tgt = 6'd0;  end
                2:       begin pos = 32'd0;         neg = 32'hFFFF_FFFF; tgt = 6'd2;  end
                3:       begin pos = 32'hA5A5_A5A5; neg = 32'h5A5A_5A5A; tgt = 6'd42; end
                default: begin pos = 32'd1 << j;    neg = 32'd1 << (j + 16); tgt = 6'(j * 3); end
            endcase
            wr_trans(8'(250 + j), pos, neg, tgt);
        end
        wr_state(8'd63, 1'b1, 8'd250, 5'd31);  // count saturates, walk wraps
        wr_state(8'd0, 1'b0, 8'd0, 5'd4);
        wr_state(8'd1, 1'b1, 8'd9, 5'd0);      // no outgoing transitions
        wr_state(8'd255, 1'b1, 8'd0, 5'd5);    // past the state table, ignored
        step_state(8'd63, 1'b0, 32'd0);
        step_state(8'd63, 1'b0, 32'hFFFF_FFFF);
        step_state(8'd63, 1'b0, 32'hA5A5_A5A5);
        step_state(8'd77, 1'b1, $urandom);
        step_state(8'd255, 1'b1, 32'hFFFF_FFFF);
        step_state(8'd1, 1'b0, $urandom);
        step_state(8'd64, 1'b0, $urandom);
        step_state(8'd255, 1'b0, $urandom);
        c      = random_cmd();
        c.kind = KIND_RSVD;
        drive_cmd(c);

        // random part; the receiver holds off first so the input queue fills
        hold_req = 1'b1;
        start    = items_sent;
        while (items_sent - start < RANDOM_ITEMS)
        begin
            if (items_sent - start >= RANDOM_ITEMS - CALM_ITEMS)
                gaps_on = 1'b0;
            if ($urandom_range(0, 9) < 7)
                run_sequence();
            else
            begin
                c = random_cmd();
                if (c.kind == KIND_STEP)
                    step_any();
                else
                    drive_cmd(c);
            end
        end
        @(negedge clk);
        s_axis_tvalid <= 1'b0;

        // drain, then let a full walk's worth of cycles pass
        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("run covered %0d table writes and %0d steps, %0d successors, %0d transfers checked",
                 sb.writes, sb.steps, sb.successors, sb.results);
        $display("receiver held off %0d cycles once with the sender still offering items",
                 HOLD_CYCLES);
        if (sb.errors == 0)
            $display("tb_buchi_product_successor_top: done, clean");
        else
            $display("tb_buchi_product_successor_top: done, errors");
        $finish;
    end

endmodule
